@@ design/bse_pkg.sv @@
// ----------------------------------------------------------------------------
// Bubble sort package
// Widths, sizes and the record types that pass along the chain of sort cells.
// ----------------------------------------------------------------------------
package bse_pkg;

  localparam int CAPACITY      = 16;
  localparam int ELEMENT_WIDTH = 32;
  localparam int CNT_W         = $clog2(CAPACITY + 1);

  typedef logic signed [ELEMENT_WIDTH-1:0] elem_val_t;

  // Contents held by one cell.
  typedef struct packed {
    logic      occ;
    elem_val_t val;
  } elem_t;

  // A request travelling to the right-hand neighbour during loading.
  typedef struct packed {
    logic      vld;
    elem_val_t val;
  } link_t;

endpackage

@@ design/bse_in_if.sv @@
// ----------------------------------------------------------------------------
// Input channel
// Valid/ready channel that carries one element of a set and its end mark.
// ----------------------------------------------------------------------------
interface bse_in_if;
  logic                 valid;
  logic                 ready;
  bse_pkg::elem_val_t   value;
  logic                 last_of_set;

  modport source (output valid, output value, output last_of_set, input ready);
  modport sink   (input valid, input value, input last_of_set, output ready);
endinterface

@@ design/bse_out_if.sv @@
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one sorted element and its end mark.
// ----------------------------------------------------------------------------
interface bse_out_if;
  logic                 valid;
  logic                 ready;
  bse_pkg::elem_val_t   sorted_value;
  logic                 last_of_run;

  modport source (output valid, output sorted_value, output last_of_run, input ready);
  modport sink   (input valid, input sorted_value, input last_of_run, output ready);
endinterface

@@ design/bse_cell.sv @@
// ----------------------------------------------------------------------------
// Sort cell
// Holds one element. While loading it keeps the smaller of its own element and
// an arriving one and hands the larger to the right; while draining it takes
// the contents of its right-hand neighbour.
// ----------------------------------------------------------------------------
module bse_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           shift,
  input  bse_pkg::link_t link_in,
  input  bse_pkg::elem_t right_in,
  output bse_pkg::link_t link_out,
  output bse_pkg::elem_t elem_out
);

  logic               occ_r, occ_nxt;
  bse_pkg::elem_val_t val_r, val_nxt;
  logic               pass_vld_r, pass_vld_nxt;
  bse_pkg::elem_val_t pass_val_r, pass_val_nxt;

  always_comb begin
    occ_nxt      = occ_r;
    val_nxt      = val_r;
    pass_vld_nxt = 1'b0;
    pass_val_nxt = pass_val_r;
    if (shift) begin
      occ_nxt = right_in.occ;
      val_nxt = right_in.val;
    end else if (link_in.vld) begin
      if (!occ_r) begin
        occ_nxt = 1'b1;
        val_nxt = link_in.val;
      end else if ($signed(link_in.val) < $signed(val_r)) begin
        val_nxt      = link_in.val;
        pass_vld_nxt = 1'b1;
        pass_val_nxt = val_r;
      end else begin
        pass_vld_nxt = 1'b1;
        pass_val_nxt = link_in.val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r      <= 1'b0;
      pass_vld_r <= 1'b0;
    end else begin
      occ_r      <= occ_nxt;
      pass_vld_r <= pass_vld_nxt;
    end
    val_r      <= val_nxt;
    pass_val_r <= pass_val_nxt;
  end

  assign link_out.vld = pass_vld_r;
  assign link_out.val = pass_val_r;
  assign elem_out.occ = occ_r;
  assign elem_out.val = val_r;

endmodule

@@ design/bubble_sort_early_exit.sv @@
// ----------------------------------------------------------------------------
// Bubble sort with early exit
// Collects a marked set of signed elements and returns it in ascending order.
// ----------------------------------------------------------------------------
// A set of N elements is taken one per cycle into a chain of CAPACITY cells,
// each of which keeps the smaller value and hands the larger one to its
// right-hand neighbour; elements beyond CAPACITY are dropped. After the marked
// element the block accepts nothing while the last values travel along the
// chain, then gives one result per cycle while results are taken, smallest
// first, the chain shifting left by one cell per result. No new set is
// accepted until the last result has been taken.
module bubble_sort_early_exit (
  input  logic      clk,
  input  logic      rst_n,
  bse_in_if.sink    in_ch,
  bse_out_if.source out_ch
);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SETTLE,
    ST_DRAIN
  } state_t;

  state_t                      state_r;
  logic [bse_pkg::CNT_W-1:0]   count_r;
  bse_pkg::link_t              link [bse_pkg::CAPACITY+1];
  bse_pkg::elem_t              cell_st [bse_pkg::CAPACITY];
  logic [bse_pkg::CAPACITY-1:0] in_flight;
  logic                        in_acc;
  logic                        out_acc;
  logic                        room;
  logic                        shift;

  assign room    = (count_r < bse_pkg::CNT_W'(bse_pkg::CAPACITY));
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;
  assign shift   = out_acc;

  assign link[0].vld = in_acc && room;
  assign link[0].val = in_ch.value;

  for (genvar i = 0; i < bse_pkg::CAPACITY; i++) begin : g_cell
    bse_pkg::elem_t right;
    if (i == bse_pkg::CAPACITY - 1) begin : g_end
      assign right = '0;
    end else begin : g_mid
      assign right = cell_st[i+1];
    end
    bse_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift    (shift),
      .link_in  (link[i]),
      .right_in (right),
      .link_out (link[i+1]),
      .elem_out (cell_st[i])
    );
    assign in_flight[i] = link[i+1].vld;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
    end else begin
      case (state_r)
        ST_LOAD: begin
          if (in_acc) begin
            if (in_ch.last_of_set) begin
              state_r <= ST_SETTLE;
              count_r <= '0;
            end else if (room) begin
              count_r <= count_r + 1'b1;
            end
          end
        end
        ST_SETTLE: begin
          if (!(|in_flight)) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (out_acc && out_ch.last_of_run) begin
            state_r <= ST_LOAD;
          end
        end
        default: begin
          state_r <= ST_LOAD;
        end
      endcase
    end
  end

  assign in_ch.ready         = (state_r == ST_LOAD);
  assign out_ch.valid        = (state_r == ST_DRAIN);
  assign out_ch.sorted_value = cell_st[0].val;
  assign out_ch.last_of_run  = !cell_st[1].occ;

endmodule
